// ===== src/ketn_pkg.sv =====
// Package for the keyed every-nth thinning unit: field widths, microcode
// word layout, jump conditions, program addresses and the control store.
// No dependencies.
`default_nettype none

package ketn_pkg;

  localparam int unsigned KEY_W    = 64;
  localparam int unsigned STEP_W   = 16;
  localparam int unsigned VCNT_W   = 2;
  localparam int unsigned VAL_W    = 64;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned BITCNT_W = $clog2(CNT_W);
  localparam int unsigned PC_W     = 5;

  localparam int unsigned S_TDATA_W = 216;
  localparam int unsigned M_TDATA_W = 8;

  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_INPUT,
    C_CLEAR,
    C_STEP_LE1,
    C_FREE,
    C_KEY_HIT,
    C_NOT_LAST,
    C_REPEAT,
    C_MOD_BUSY,
    C_MOD_ONE,
    C_OUT_BUSY
  } cond_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_ONE,
    CNT_INC
  } cnt_op_e;

  typedef struct packed {
    logic            in_ready;
    cond_e           cond;
    logic [PC_W-1:0] target;
    logic            ptr_clr;
    logic            ptr_inc;
    logic            mem_rd;
    cnt_op_e         cnt_op;
    logic            mod_start;
    logic            we_cnt;
    logic            we_key;
    logic            we_vals;
    logic            we_last;
    logic            last_val;
    logic            set_valid;
    logic            clr_valid;
    logic            set_res;
    logic            res_take;
    logic            res_take_step;
    logic            res_full;
    logic            emit;
  } ctl_word_t;

  // Program addresses
  localparam logic [PC_W-1:0] A_IDLE  = 5'd0;
  localparam logic [PC_W-1:0] A_DISP  = 5'd1;
  localparam logic [PC_W-1:0] A_START = 5'd2;
  localparam logic [PC_W-1:0] A_SCAN  = 5'd3;
  localparam logic [PC_W-1:0] A_CMP   = 5'd4;
  localparam logic [PC_W-1:0] A_NEXT  = 5'd5;
  localparam logic [PC_W-1:0] A_FULL  = 5'd6;
  localparam logic [PC_W-1:0] A_HIT   = 5'd7;
  localparam logic [PC_W-1:0] A_INC   = 5'd8;
  localparam logic [PC_W-1:0] A_MODGO = 5'd9;
  localparam logic [PC_W-1:0] A_WAIT  = 5'd10;
  localparam logic [PC_W-1:0] A_TEST  = 5'd11;
  localparam logic [PC_W-1:0] A_DROP  = 5'd12;
  localparam logic [PC_W-1:0] A_KEEP  = 5'd13;
  localparam logic [PC_W-1:0] A_NEW   = 5'd14;
  localparam logic [PC_W-1:0] A_NEWWR = 5'd15;
  localparam logic [PC_W-1:0] A_TAKE  = 5'd16;
  localparam logic [PC_W-1:0] A_CLR   = 5'd17;
  localparam logic [PC_W-1:0] A_SMALL = 5'd18;
  localparam logic [PC_W-1:0] A_EMIT  = 5'd19;
  localparam logic [PC_W-1:0] A_BACK  = 5'd20;

  function automatic ctl_word_t ucode(input logic [PC_W-1:0] pc);
    ctl_word_t w;
    w        = '0;
    w.cond   = C_NONE;
    w.cnt_op = CNT_HOLD;
    w.target = A_IDLE;
    unique case (pc)
      A_IDLE: begin
        w.in_ready = 1'b1;
        w.cond     = C_NO_INPUT;
        w.target   = A_IDLE;
      end
      A_DISP: begin
        w.cond   = C_CLEAR;
        w.target = A_CLR;
      end
      A_START: begin
        w.ptr_clr = 1'b1;
        w.cond    = C_STEP_LE1;
        w.target  = A_SMALL;
      end
      A_SCAN: begin
        w.mem_rd = 1'b1;
        w.cond   = C_FREE;
        w.target = A_NEW;
      end
      A_CMP: begin
        w.cond   = C_KEY_HIT;
        w.target = A_HIT;
      end
      A_NEXT: begin
        w.ptr_inc = 1'b1;
        w.cond    = C_NOT_LAST;
        w.target  = A_SCAN;
      end
      A_FULL: begin
        w.set_res  = 1'b1;
        w.res_full = 1'b1;
        w.cond     = C_ALWAYS;
        w.target   = A_EMIT;
      end
      A_HIT: begin
        w.cond   = C_REPEAT;
        w.target = A_TAKE;
      end
      A_INC: begin
        w.cnt_op = CNT_INC;
      end
      A_MODGO: begin
        w.mod_start = 1'b1;
      end
      A_WAIT: begin
        w.cond   = C_MOD_BUSY;
        w.target = A_WAIT;
      end
      A_TEST: begin
        w.cond   = C_MOD_ONE;
        w.target = A_KEEP;
      end
      A_DROP: begin
        w.we_cnt  = 1'b1;
        w.we_last = 1'b1;
        w.set_res = 1'b1;
        w.cond    = C_ALWAYS;
        w.target  = A_EMIT;
      end
      A_KEEP: begin
        w.we_cnt   = 1'b1;
        w.we_vals  = 1'b1;
        w.we_last  = 1'b1;
        w.last_val = 1'b1;
        w.set_res  = 1'b1;
        w.res_take = 1'b1;
        w.cond     = C_ALWAYS;
        w.target   = A_EMIT;
      end
      A_NEW: begin
        w.cnt_op = CNT_ONE;
      end
      A_NEWWR: begin
        w.we_cnt    = 1'b1;
        w.we_key    = 1'b1;
        w.we_vals   = 1'b1;
        w.we_last   = 1'b1;
        w.last_val  = 1'b1;
        w.set_valid = 1'b1;
        w.set_res   = 1'b1;
        w.res_take  = 1'b1;
        w.cond      = C_ALWAYS;
        w.target    = A_EMIT;
      end
      A_TAKE: begin
        w.set_res  = 1'b1;
        w.res_take = 1'b1;
        w.cond     = C_ALWAYS;
        w.target   = A_EMIT;
      end
      A_CLR: begin
        w.clr_valid = 1'b1;
        w.set_res   = 1'b1;
        w.cond      = C_ALWAYS;
        w.target    = A_EMIT;
      end
      A_SMALL: begin
        w.set_res       = 1'b1;
        w.res_take_step = 1'b1;
        w.cond          = C_ALWAYS;
        w.target        = A_EMIT;
      end
      A_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = C_OUT_BUSY;
        w.target = A_EMIT;
      end
      A_BACK: begin
        w.cond   = C_ALWAYS;
        w.target = A_IDLE;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = A_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== src/keyed_every_nth_thinning_unit.sv =====
// Top level of the keyed every-nth thinning unit: microcoded sequencer,
// stream table memories and result register. Depends on ketn_pkg, ketn_mod_unit.
//
// channel  dir  tdata                                            tuser
// s_axis   in   key, step_n, value_count, val_a, val_b           req_type
// m_axis   out  take                                             table_full
//
// A new record is taken only once the result of the last one is in the output
// register. A lookup scans the entries in order; a new key goes to the first free
// entry, and a count advance waits on the bit-serial remainder.
// Reset clears the entry valid bits, the sequencer and the output valid bit.
// A finished result waits in the output register; the next record is taken
// meanwhile and only its own result stalls on a busy output.
`default_nettype none

module keyed_every_nth_thinning_unit #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [63:0] stream_key, [79:64] step_n, [81:80] value_count,
  // [145:82] val_a, [209:146] val_b, [215:210] zero
  input  wire logic [ketn_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // [0] req_type
  input  wire logic [0:0]                         s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [0] take, [7:1] zero
  output logic [ketn_pkg::M_TDATA_W-1:0]          m_axis_tdata,
  // [0] table_full
  output logic [0:0]                              m_axis_tuser
);

  localparam int unsigned PTR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TABLE_ENTRIES - 1);

  ketn_pkg::ctl_word_t ctl;
  logic [ketn_pkg::PC_W-1:0] pc_q, pc_d;
  logic jump;

  // captured record
  logic                          req_q;
  logic [ketn_pkg::KEY_W-1:0]    key_q;
  logic [ketn_pkg::STEP_W-1:0]   step_q;
  logic [ketn_pkg::VCNT_W-1:0]   vc_q;
  logic [ketn_pkg::VAL_W-1:0]    v1_q;
  logic [ketn_pkg::VAL_W-1:0]    v2_q;
  logic                          in_fire;
  logic [ketn_pkg::VCNT_W-1:0]   in_vc;

  // table
  logic [TABLE_ENTRIES-1:0]      valid_q;
  logic [PTR_W-1:0]              ptr_q;
  logic [ketn_pkg::CNT_W-1:0]    cnt_mem    [TABLE_ENTRIES];
  logic [ketn_pkg::KEY_W-1:0]    key_mem    [TABLE_ENTRIES];
  logic [ketn_pkg::VAL_W-1:0]    first_mem  [TABLE_ENTRIES];
  logic [ketn_pkg::VAL_W-1:0]    second_mem [TABLE_ENTRIES];
  logic [ketn_pkg::VCNT_W-1:0]   vc_mem     [TABLE_ENTRIES];
  logic                          last_mem   [TABLE_ENTRIES];
  logic [ketn_pkg::CNT_W-1:0]    rd_cnt_q;
  logic [ketn_pkg::KEY_W-1:0]    rd_key_q;
  logic [ketn_pkg::VAL_W-1:0]    rd_first_q;
  logic [ketn_pkg::VAL_W-1:0]    rd_second_q;
  logic [ketn_pkg::VCNT_W-1:0]   rd_vc_q;
  logic                          rd_last_q;

  logic [ketn_pkg::CNT_W-1:0]    cnt_q;
  logic [ketn_pkg::CNT_W-1:0]    cnt_inc;
  logic                          mod_busy;
  logic [ketn_pkg::STEP_W-1:0]   mod_rem;
  logic                          repeat_hit;

  // result
  logic res_take_q, res_full_q;
  logic out_vld_q, out_take_q, out_full_q;
  logic out_busy, emit_fire;

  always_comb begin
    ctl = ketn_pkg::ucode(pc_q);
  end

  assign s_axis_tready = ctl.in_ready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_vc         = s_axis_tdata[81:80];
  assign out_busy      = out_vld_q && !m_axis_tready;
  assign emit_fire     = ctl.emit && !out_busy;
  assign repeat_hit    = rd_last_q && (rd_vc_q == vc_q) &&
                         (rd_first_q == v1_q) && (rd_second_q == v2_q);

  always_comb begin
    unique case (ctl.cond)
      ketn_pkg::C_NONE:     jump = 1'b0;
      ketn_pkg::C_ALWAYS:   jump = 1'b1;
      ketn_pkg::C_NO_INPUT: jump = !s_axis_tvalid;
      ketn_pkg::C_CLEAR:    jump = req_q;
      ketn_pkg::C_STEP_LE1: jump = (step_q[ketn_pkg::STEP_W-1:1] == '0);
      ketn_pkg::C_FREE:     jump = !valid_q[ptr_q];
      ketn_pkg::C_KEY_HIT:  jump = (rd_key_q == key_q);
      ketn_pkg::C_NOT_LAST: jump = (ptr_q != PTR_LAST);
      ketn_pkg::C_REPEAT:   jump = repeat_hit;
      ketn_pkg::C_MOD_BUSY: jump = mod_busy;
      ketn_pkg::C_MOD_ONE:  jump = (mod_rem == ketn_pkg::STEP_W'(1));
      ketn_pkg::C_OUT_BUSY: jump = out_busy;
      default:              jump = 1'b0;
    endcase
  end

  always_comb begin
    pc_d = jump ? ctl.target : pc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ketn_pkg::A_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  // absent values read as zero
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q  <= s_axis_tuser[0];
      key_q  <= s_axis_tdata[63:0];
      step_q <= s_axis_tdata[79:64];
      vc_q   <= in_vc;
      v1_q   <= (in_vc != 2'd0) ? s_axis_tdata[145:82] : '0;
      v2_q   <= in_vc[1] ? s_axis_tdata[209:146] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctl.clr_valid) begin
      valid_q <= '0;
    end else if (ctl.set_valid) begin
      valid_q[ptr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.ptr_clr) begin
      ptr_q <= '0;
    end else if (ctl.ptr_inc) begin
      ptr_q <= ptr_q + 1'b1;
    end
  end

  // count wraps from all ones to one
  assign cnt_inc = (rd_cnt_q == '1) ? ketn_pkg::CNT_W'(1) : rd_cnt_q + 1'b1;

  always_ff @(posedge clk_i) begin
    case (ctl.cnt_op)
      ketn_pkg::CNT_ONE: cnt_q <= ketn_pkg::CNT_W'(1);
      ketn_pkg::CNT_INC: cnt_q <= cnt_inc;
      default:           cnt_q <= cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl.we_cnt) begin
      cnt_mem[ptr_q] <= cnt_q;
    end
    if (ctl.we_key) begin
      key_mem[ptr_q] <= key_q;
    end
    if (ctl.we_vals) begin
      first_mem[ptr_q]  <= v1_q;
      second_mem[ptr_q] <= v2_q;
      vc_mem[ptr_q]     <= vc_q;
    end
    if (ctl.we_last) begin
      last_mem[ptr_q] <= ctl.last_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.mem_rd) begin
      rd_cnt_q    <= cnt_mem[ptr_q];
      rd_key_q    <= key_mem[ptr_q];
      rd_first_q  <= first_mem[ptr_q];
      rd_second_q <= second_mem[ptr_q];
      rd_vc_q     <= vc_mem[ptr_q];
      rd_last_q   <= last_mem[ptr_q];
    end
  end

  ketn_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl.mod_start),
    .dividend_i (cnt_q),
    .divisor_i  (step_q),
    .busy_o     (mod_busy),
    .rem_o      (mod_rem)
  );

  always_ff @(posedge clk_i) begin
    if (ctl.set_res) begin
      res_take_q <= ctl.res_take_step ? step_q[0] : ctl.res_take;
      res_full_q <= ctl.res_full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit_fire) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_take_q <= res_take_q;
      out_full_q <= res_full_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(ketn_pkg::M_TDATA_W-1)'(0), out_take_q};
  assign m_axis_tuser  = out_full_q;

  a_full_needs_all_valid: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (emit_fire && res_full_q) |-> (&valid_q)
  ) else $error("table_full reported with a free entry");

  a_mod_only_in_wait: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    mod_busy |-> (pc_q == ketn_pkg::A_WAIT)
  ) else $error("remainder unit busy outside its wait step");

  a_count_write_in_use: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (ctl.we_cnt && !ctl.set_valid) |-> valid_q[ptr_q]
  ) else $error("count written to an unused entry");

  a_no_accept_while_busy: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (mod_busy || ctl.mem_rd) |-> !s_axis_tready
  ) else $error("record transfer taken mid-operation");

endmodule

`default_nettype wire

// ===== src/ketn_mod_unit.sv =====
// Bit-serial remainder unit: 32-bit count modulo 16-bit step, one bit a cycle.
// Depends on ketn_pkg.
`default_nettype none

module ketn_mod_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [ketn_pkg::CNT_W-1:0]       dividend_i,
  input  wire logic [ketn_pkg::STEP_W-1:0]      divisor_i,
  output logic                                  busy_o,
  output logic [ketn_pkg::STEP_W-1:0]           rem_o
);

  logic                              busy_q;
  logic [ketn_pkg::BITCNT_W-1:0]     bit_q;
  logic [ketn_pkg::CNT_W-1:0]        dvd_q;
  logic [ketn_pkg::STEP_W-1:0]       rem_q;
  logic [ketn_pkg::STEP_W:0]         trial;
  logic [ketn_pkg::STEP_W+1:0]       diff;
  logic [ketn_pkg::STEP_W-1:0]       rem_d;

  always_comb begin
    trial = {rem_q, dvd_q[ketn_pkg::CNT_W-1]};
    diff  = {1'b0, trial} - {2'b00, divisor_i};
    rem_d = diff[ketn_pkg::STEP_W+1] ? trial[ketn_pkg::STEP_W-1:0]
                                     : diff[ketn_pkg::STEP_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && (bit_q == '0)) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      bit_q <= '1;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[ketn_pkg::CNT_W-2:0], 1'b0};
      rem_q <= rem_d;
      bit_q <= bit_q - 1'b1;
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== bench/keyed_every_nth_thinning_unit_tb.sv =====
// Testbench for keyed_every_nth_thinning_unit: directed and random record streams
// with a class scoreboard that predicts each take/table_full verdict.
// Depends on ketn_pkg and keyed_every_nth_thinning_unit.
`timescale 1ns / 100ps

module keyed_every_nth_thinning_unit_tb;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned KEY_POOL   = 12;
  localparam int unsigned VAL_POOL   = 4;
  localparam int unsigned RAND_ITEMS = 550;
  localparam int unsigned STALL_MAX  = 4000;
  localparam int unsigned TAIL       = 200;
  localparam bit REQ_THIN  = 1'b0;
  localparam bit REQ_CLEAR = 1'b1;

  typedef struct {
    bit          req;
    logic [63:0] key;
    logic [15:0] step;
    logic [1:0]  vcnt;
    logic [63:0] first;
    logic [63:0] second;
  } record_t;

  typedef struct {
    bit take;
    bit full;
  } verdict_t;

  class thinning_scoreboard;
    logic [31:0] ent_count  [DEPTH];
    logic [63:0] ent_key    [DEPTH];
    bit          ent_last   [DEPTH];
    logic [63:0] ent_first  [DEPTH];
    logic [63:0] ent_second [DEPTH];
    logic [1:0]  ent_vcnt   [DEPTH];
    verdict_t    pending_verdicts[$];
    int unsigned records, clears, checked, takes, fulls, errors;

    function new();
      for (int e = 0; e < DEPTH; e++) begin
        ent_count[e] = '0;
        ent_last[e]  = 1'b0;
      end
    endfunction

    function automatic verdict_t thin_record(record_t r);
      verdict_t    v;
      logic [63:0] a, b;
      logic [31:0] c;
      int          hit;
      v.take = 1'b0;
      v.full = 1'b0;
      a = (r.vcnt >= 2'd1) ? r.first : '0;
      b = (r.vcnt >= 2'd2) ? r.second : '0;
      hit = -1;
      if (r.req == REQ_CLEAR) begin
        for (int e = 0; e < DEPTH; e++) ent_count[e] = '0;
        return v;
      end
      if (r.step <= 16'd1) begin
        v.take = r.step[0];
        return v;
      end
      for (int e = 0; e < DEPTH; e++) begin
        if (hit < 0 && (ent_count[e] == '0 || ent_key[e] == r.key)) hit = e;
      end
      if (hit < 0) begin
        v.full = 1'b1;
        return v;
      end
      if (ent_count[hit] == '0) begin
        ent_count[hit] = 32'd1;
        ent_key[hit]   = r.key;
        ent_last[hit]  = 1'b1;
        ent_first[hit] = a;
        ent_second[hit] = b;
        ent_vcnt[hit]  = r.vcnt;
        v.take = 1'b1;
      end else if (ent_last[hit] && ent_vcnt[hit] == r.vcnt &&
                   ent_first[hit] == a && ent_second[hit] == b) begin
        v.take = 1'b1;
      end else begin
        c = ent_count[hit] + 32'd1;
        if (c == '0) c = 32'd1;
        ent_count[hit] = c;
        if (c % {16'd0, r.step} == 32'd1) begin
          ent_last[hit]   = 1'b1;
          ent_first[hit]  = a;
          ent_second[hit] = b;
          ent_vcnt[hit]   = r.vcnt;
          v.take = 1'b1;
        end else begin
          ent_last[hit] = 1'b0;
        end
      end
      return v;
    endfunction

    function void note_input(record_t r);
      records++;
      if (r.req == REQ_CLEAR) clears++;
      pending_verdicts.push_back(thin_record(r));
    endfunction

    function void check_result(bit take, bit full);
      verdict_t exp_v;
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result: take=%0b table_full=%0b", take, full);
        errors++;
        return;
      end
      exp_v = pending_verdicts.pop_front();
      checked++;
      if (take) takes++;
      if (full) fulls++;
      if (take !== exp_v.take) begin
        $error("take: expected %0b, got %0b", exp_v.take, take);
        errors++;
      end
      if (full !== exp_v.full) begin
        $error("table_full: expected %0b, got %0b", exp_v.full, full);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [ketn_pkg::S_TDATA_W-1:0] s_axis_tdata;
  logic [0:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [ketn_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;

  thinning_scoreboard sb = new();
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned stall_cycles;
  logic [63:0] key_pool [KEY_POOL];
  logic [63:0] val_pool [VAL_POOL];

  keyed_every_nth_thinning_unit #(
    .TABLE_ENTRIES(DEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata[0], m_axis_tuser[0]);
    end
  end

  // no-progress watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("keyed_every_nth_thinning_unit_tb: done, errors");
        $finish;
      end
    end
  end

  function automatic record_t mk_rec(bit req, logic [63:0] k, logic [15:0] n,
                                     logic [1:0] vc, logic [63:0] a, logic [63:0] b);
    record_t r;
    r.req    = req;
    r.key    = k;
    r.step   = n;
    r.vcnt   = vc;
    r.first  = a;
    r.second = b;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic record_t rand_rec();
    record_t     r;
    int unsigned roll;
    r.req = ($urandom_range(0, 99) < 3) ? REQ_CLEAR : REQ_THIN;
    r.key = ($urandom_range(0, 99) < 90) ? key_pool[$urandom_range(0, KEY_POOL-1)] : rand64();
    roll = $urandom_range(0, 99);
    if (roll < 5)       r.step = 16'd0;
    else if (roll < 10) r.step = 16'd1;
    else if (roll < 80) r.step = 16'($urandom_range(2, 5));
    else if (roll < 90) r.step = 16'($urandom_range(6, 40));
    else                r.step = 16'($urandom);
    r.vcnt   = ($urandom_range(0, 1) == 0) ? 2'd2 : 2'($urandom_range(0, 3));
    r.first  = ($urandom_range(0, 99) < 60) ? val_pool[$urandom_range(0, VAL_POOL-1)] : rand64();
    r.second = ($urandom_range(0, 99) < 60) ? val_pool[$urandom_range(0, VAL_POOL-1)] : rand64();
    return r;
  endfunction

  task automatic send_item(record_t r);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, r.second, r.first, r.vcnt, r.step, r.key};
    s_axis_tuser  <= r.req;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(r);
  endtask

  initial begin
    logic [63:0] key_a, va, vb;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    src_idle_pct  = 25;
    snk_idle_pct  = 60;
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = rand64();
    for (int i = 0; i < VAL_POOL; i++) val_pool[i] = rand64();
    key_pool[0] = '0;
    key_pool[1] = '1;
    val_pool[0] = '0;
    val_pool[1] = '1;
    key_a = 64'h0123_4567_89ab_cdef;
    va    = rand64();
    vb    = rand64();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // step 0 / step 1 / clear with junk fields
    send_item(mk_rec(REQ_THIN, '0, 16'd0, 2'd0, '1, '1));
    send_item(mk_rec(REQ_THIN, '1, 16'd1, 2'd2, '0, '0));
    send_item(mk_rec(REQ_CLEAR, '1, '1, 2'd3, '1, '1));
    // new entry, repeat, count and absent-value handling
    send_item(mk_rec(REQ_THIN, key_a, 16'd2, 2'd2, va, vb));
    send_item(mk_rec(REQ_THIN, key_a, 16'd2, 2'd2, va, vb));
    send_item(mk_rec(REQ_THIN, key_a, 16'd2, 2'd1, va, '1));
    send_item(mk_rec(REQ_THIN, key_a, 16'd2, 2'd1, va, vb));
    send_item(mk_rec(REQ_THIN, key_a, 16'd2, 2'd1, va, ~vb));
    // value count three vs two
    send_item(mk_rec(REQ_THIN, key_a, 16'd2, 2'd3, va, vb));
    send_item(mk_rec(REQ_THIN, key_a, 16'd2, 2'd3, va, vb));
    send_item(mk_rec(REQ_THIN, key_a, 16'd2, 2'd2, va, vb));
    send_item(mk_rec(REQ_THIN, '1, 16'hffff, 2'd2, '0, '0));
    // fill the table, last one overflows
    for (int i = 0; i < DEPTH - 1; i++) begin
      send_item(mk_rec(REQ_THIN, (i == 0) ? 64'd0 : {$urandom, 32'(i)}, 16'd3,
                       2'($urandom_range(0, 3)), rand64(), rand64()));
    end

    for (int p = 0; p < 3; p++) begin
      src_idle_pct = (p == 0) ? 25 : (p == 1) ? 60 : 0;
      snk_idle_pct = (p == 0) ? 60 : (p == 1) ? 25 : 0;
      for (int i = 0; i < RAND_ITEMS / 3; i++) send_item(rand_rec());
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (sb.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);

    $display("%0d records sent (%0d clears); %0d verdicts checked, %0d takes, %0d table-full",
             sb.records, sb.clears, sb.checked, sb.takes, sb.fulls);
    if (sb.errors == 0) begin
      $display("keyed_every_nth_thinning_unit_tb: done, clean");
    end else begin
      $display("keyed_every_nth_thinning_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
